@@ rtl/sm64_pkg.sv @@
// ----------------------------------------------------------------------------
// sm64_pkg
// Shared types and constants of the splitmix64 ranged generator.
// ----------------------------------------------------------------------------
package sm64_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_ONE = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_TWO = 64'h94d049bb133111eb;

  typedef enum logic [2:0] {
    MODE_RAW64   = 3'd0,
    MODE_TOP32   = 3'd1,
    MODE_URANGE  = 3'd2,
    MODE_SRANGE  = 3'd3,
    MODE_BOOL    = 3'd4,
    MODE_FRAC24  = 3'd5,
    MODE_FRAC53  = 3'd6,
    MODE_SPARE   = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_LIMIT, ST_DRAW, ST_MIX, ST_CHECK, ST_REDUCE, ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture request and compute bounds
    logic div_start;   // start a 64-bit modulo
    logic div_sel;     // 0: limit modulo, 1: sample modulo
    logic draw_step;   // advance state and count
    logic mix_start;   // start finalizer
    logic out_load;    // load output register
  } cmd_t;

  typedef struct packed {
    logic is_range;
    logic div_done;
    logic mix_done;
    logic reject;
  } status_t;

endpackage

@@ rtl/splitmix64_ranged_generator_unit.sv @@
// ----------------------------------------------------------------------------
// splitmix64_ranged_generator_unit
// Splitmix64 generator with raw, top-32, boolean, fraction and rejection-sampled range requests.
// ----------------------------------------------------------------------------
// Plain modes run one draw through the nine-phase finalizer; range modes also run
// the 64-step modulo unit once for the limit and once for the reduction, and each
// rejected draw repeats the draw and the finalizer. Output stalls delay both.
// One item is in flight at a time; the output register frees the input side.
// Reset (synchronous, active high) clears state, seed and draw count to zero.
module splitmix64_ranged_generator_unit import sm64_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // mode[2:0], bound_a[34:3], bound_b[66:35], zeros
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // value[63:0], draw_count[127:64]
);

  cmd_t    cmd;
  status_t stat;
  logic    busy, in_fire, out_free;
  logic [127:0] result;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  sm64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  sm64_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_valid),
    .cfg_seed (cfg_data),
    .mode     (s_axis_tdata[2:0]),
    .bound_a  (s_axis_tdata[34:3]),
    .bound_b  (s_axis_tdata[66:35]),
    .stat     (stat),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_axis_tdata <= result;
  end

endmodule

@@ rtl/sm64_ctrl.sv @@
// ----------------------------------------------------------------------------
// sm64_ctrl
// Controller sequencing draws, rejection and modulo steps.
// ----------------------------------------------------------------------------
module sm64_ctrl import sm64_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    out_free,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_SETUP;
      ST_SETUP:  state_next = stat.is_range ? ST_LIMIT : ST_DRAW;
      ST_LIMIT:  if (stat.div_done) state_next = ST_DRAW;
      ST_DRAW:   state_next = ST_MIX;
      ST_MIX:    if (stat.mix_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!stat.is_range) state_next = ST_DONE;
        else if (stat.reject) state_next = ST_DRAW;
        else state_next = ST_REDUCE;
      end
      ST_REDUCE: if (stat.div_done) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.load_req = in_fire;
      ST_SETUP:  cmd.div_start = stat.is_range;
      ST_DRAW: begin
        cmd.draw_step = 1'b1;
        cmd.mix_start = 1'b1;
      end
      ST_CHECK: begin
        cmd.div_start = stat.is_range && !stat.reject;
        cmd.div_sel   = 1'b1;
      end
      ST_REDUCE: cmd.div_sel = 1'b1;
      ST_DONE:   cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ rtl/sm64_div.sv @@
// ----------------------------------------------------------------------------
// sm64_div
// Restoring 64-bit by 33-bit modulo, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sm64_div import sm64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] rem
);

  logic [63:0] num;
  logic [33:0] part;
  logic [6:0]  cnt;
  logic        run;
  logic [33:0] shifted;
  logic [34:0] diff;

  assign shifted = {part[32:0], num[63]};
  assign diff    = {1'b0, shifted} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 7'd0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      part <= '0;
    end else if (run) begin
      num  <= {num[62:0], 1'b0};
      part <= diff[34] ? shifted : diff[33:0];
    end
  end

  assign rem = part[32:0];

endmodule

@@ rtl/sm64_dp.sv @@
// ----------------------------------------------------------------------------
// sm64_dp
// Datapath: generator state, finalizer, range setup and result shaping.
// ----------------------------------------------------------------------------
module sm64_dp import sm64_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_seed,
  input  logic [2:0]   mode,
  input  logic [31:0]  bound_a,
  input  logic [31:0]  bound_b,
  output status_t      stat,
  output logic [127:0] result
);

  logic [63:0] gen_state, draws_done;
  logic [2:0]  req_mode;
  logic [31:0] lo;
  logic [32:0] range;
  logic [32:0] limit;
  logic [63:0] sample, x;
  logic [3:0]  mix_ph;
  logic        mix_run, mix_done;
  logic [63:0] acc, prod, mul_k;
  logic [31:0] mul_a, mul_b;
  logic        swap;
  logic [31:0] lo_sel, hi_sel;
  logic        div_start, div_done;
  logic [32:0] div_rem;
  logic [63:0] div_num;
  logic        limit_pending;
  logic [63:0] result_value;

  always_comb begin
    if (mode == MODE_SRANGE) swap = ($signed(bound_a) > $signed(bound_b));
    else                     swap = (bound_a > bound_b);
    lo_sel = swap ? bound_b : bound_a;
    hi_sel = swap ? bound_a : bound_b;
  end

  // Seed writes are for the user to make only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state  <= '0;
      draws_done <= '0;
    end else if (cfg_we) begin
      gen_state  <= cfg_seed;
      draws_done <= '0;
    end else if (cmd.draw_step) begin
      gen_state  <= gen_state + GOLDEN_STEP;
      draws_done <= draws_done + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= mode;
      lo       <= lo_sel;
      range    <= {1'b0, hi_sel - lo_sel} + 33'd1;
    end
  end

  // Finalizer over nine phases. Each multiply keeps the low 64 bits of the product
  // and is built from three 32 x 32 partial products, one per cycle: the low halves
  // first, then the two cross terms shifted up by 32.
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_run  <= 1'b0;
      mix_done <= 1'b0;
      mix_ph   <= '0;
    end else begin
      mix_done <= 1'b0;
      if (cmd.mix_start) begin
        mix_run <= 1'b1;
        mix_ph  <= '0;
      end else if (mix_run) begin
        mix_ph <= mix_ph + 4'd1;
        if (mix_ph == 4'd8) begin
          mix_run  <= 1'b0;
          mix_done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    mul_k = (mix_ph < 4'd4) ? MIX_MUL_ONE : MIX_MUL_TWO;
    case (mix_ph) inside
      4'd2, 4'd6: begin
        mul_a = x[63:32];
        mul_b = mul_k[31:0];
      end
      4'd3, 4'd7: begin
        mul_a = x[31:0];
        mul_b = mul_k[63:32];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = mul_k[31:0];
      end
    endcase
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    if (cmd.mix_start) x <= gen_state + GOLDEN_STEP;
    else if (mix_run) begin
      case (mix_ph) inside
        4'd0:       x   <= x ^ (x >> 30);
        4'd1, 4'd5: acc <= prod;
        4'd2, 4'd6: acc <= acc + {prod[31:0], 32'd0};
        4'd3, 4'd7: x   <= acc + {prod[31:0], 32'd0};
        4'd4:       x   <= x ^ (x >> 27);
        default:    x   <= x ^ (x >> 31);
      endcase
    end
  end
  assign sample = x;

  // The limit is (2^64 - range) mod range.
  assign div_start = cmd.div_start;
  assign div_num   = cmd.div_sel ? sample : (64'd0 - {31'd0, range});

  always_ff @(posedge clk) begin
    if (rst) limit_pending <= 1'b0;
    else if (cmd.div_start) limit_pending <= !cmd.div_sel;
    else if (div_done) limit_pending <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (div_done && limit_pending) limit <= div_rem;
  end

  sm64_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (range),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign stat.is_range = (req_mode == MODE_URANGE) || (req_mode == MODE_SRANGE);
  assign stat.div_done = div_done;
  assign stat.mix_done = mix_done;
  assign stat.reject   = (sample < {31'd0, limit});

  logic [31:0] ranged;
  assign ranged = lo + div_rem[31:0];

  always_ff @(posedge clk) begin
    if (div_done && !limit_pending) result_value <= {32'd0, ranged};
    else if (mix_done) begin
      case (req_mode)
        MODE_TOP32:  result_value <= {32'd0, sample[63:32]};
        MODE_BOOL:   result_value <= {63'd0, sample[0]};
        MODE_FRAC24: result_value <= {40'd0, sample[63:40]};
        MODE_FRAC53: result_value <= {11'd0, sample[63:11]};
        default:     result_value <= sample;
      endcase
    end
  end
  assign result = {draws_done, result_value};

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the splitmix64 ranged generator. Requests are driven
// through the input stream, every result is predicted in the testbench and
// checked field by field, and the seed is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sm64_pkg::*;

  typedef struct packed {
    logic [31:0] bound_b;
    logic [31:0] bound_a;
    mode_t       mode;
  } request_t;

  typedef struct packed {
    logic [63:0] draw_count;
    logic [63:0] value;
  } result_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int NUM_RANDOM = 480;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  logic [63:0] model_state;
  logic [63:0] model_draws;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int queued_count = 0;
  int seed_writes = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int idle_cycles = 0;
  bit cfg_pending = 1'b0;

  splitmix64_ranged_generator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] next_draw();
    logic [63:0] x;
    model_state = model_state + GOLDEN_STEP;
    model_draws = model_draws + 64'd1;
    x = model_state;
    x = (x ^ (x >> 30)) * MIX_MUL_ONE;
    x = (x ^ (x >> 27)) * MIX_MUL_TWO;
    return x ^ (x >> 31);
  endfunction

  // Rejection sampling over [lo, lo + span]; span + 1 is at most 2^32.
  // The sum wraps at 32 bits, as a signed range may cross zero.
  function automatic logic [63:0] ranged_pick(logic [31:0] lo, logic [31:0] span);
    logic [63:0] range;
    logic [63:0] reject_below;
    logic [63:0] sample;
    logic [63:0] offset;
    range = {32'd0, span} + 64'd1;
    reject_below = (64'd0 - range) % range;
    sample = next_draw();
    while (sample < reject_below) sample = next_draw();
    offset = sample % range;
    return {32'd0, lo + offset[31:0]};
  endfunction

  function automatic result_t predict_result(request_t req);
    result_t res;
    logic [31:0] lo;
    logic [31:0] hi;
    lo = req.bound_a;
    hi = req.bound_b;
    case (req.mode)
      MODE_TOP32:  res.value = next_draw() >> 32;
      MODE_URANGE: begin
        if (lo > hi) begin lo = req.bound_b; hi = req.bound_a; end
        res.value = ranged_pick(lo, hi - lo);
      end
      MODE_SRANGE: begin
        if ($signed(lo) > $signed(hi)) begin lo = req.bound_b; hi = req.bound_a; end
        res.value = ranged_pick(lo, hi - lo);
      end
      MODE_BOOL:   res.value = next_draw() & 64'd1;
      MODE_FRAC24: res.value = next_draw() >> 40;
      MODE_FRAC53: res.value = next_draw() >> 11;
      default:     res.value = next_draw();
    endcase
    res.draw_count = model_draws;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h want %h", checked_count, what, got, want);
    error_count++;
  endtask

  task automatic queue_request(request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
    queued_count++;
  endtask

  // Request source.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      expected_results.insert(expected_results.size(),
                              predict_result(request_t'(s_axis_tdata[66:0])));
      sent_count++;
      s_axis_tvalid <= 1'b0;
      send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    end else if (!s_axis_tvalid && pending_reqs.size() > 0 && !cfg_pending) begin
      if (send_wait > 0) send_wait <= send_wait - 1;
      else begin
        s_axis_tdata <= {5'd0, pending_reqs.pop_front()};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Result sink and checker.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected value", got.value, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) report_mismatch("value", got.value, want.value);
          if (got.draw_count !== want.draw_count)
            report_mismatch("draw_count", got.draw_count, want.draw_count);
        end
        checked_count++;
        m_axis_tready <= 1'b0;
        recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end else if (!m_axis_tready) begin
        if (recv_wait > 0) recv_wait <= recv_wait - 1;
        else m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic request_t make_req(mode_t m, logic [31:0] a, logic [31:0] b);
    request_t r;
    r.mode = m;
    r.bound_a = a;
    r.bound_b = b;
    return r;
  endfunction

  // Small ranges in half of the cases so that rejection is rare, random and huge ones in the rest to exercise it.
  function automatic request_t random_req();
    request_t r;
    logic [31:0] base;
    r.mode = mode_t'($urandom_range(0, 7));
    base = $urandom;
    case ($urandom_range(0, 3))
      0: begin r.bound_a = base; r.bound_b = base + $urandom_range(0, 20); end
      1: begin r.bound_a = $urandom; r.bound_b = $urandom; end
      2: begin r.bound_a = base; r.bound_b = base - $urandom_range(0, 1000); end
      default: begin r.bound_a = 32'h8000_0000 ^ base[0 +: 1]; r.bound_b = ~base; end
    endcase
    if ($urandom_range(0, 1)) r = {r.bound_a, r.bound_b, r.mode};
    return r;
  endfunction

  // Every queued request has come back as a checked result.
  task automatic wait_drained();
    while (checked_count < queued_count)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Seed write while the block is idle; the model follows at the transfer.
  task automatic write_seed(logic [63:0] value);
    cfg_pending = 1'b1;
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_state = value;
    model_draws = '0;
    seed_writes++;
    cfg_pending = 1'b0;
  endtask

  initial begin
    logic [63:0] seeds[4];
    model_state = '0;
    model_draws = '0;
    seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[1] = {$urandom, $urandom};
    seeds[2] = 64'h0;
    seeds[3] = 64'h8000_0000_0000_0001;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed requests from the reset seed: every mode, bound extremes, reversed
    // bounds, single-value ranges and the full 32-bit range in both range modes.
    for (int m = 0; m < 8; m++) queue_request(make_req(mode_t'(m), '1, '0));
    queue_request(make_req(MODE_URANGE, 32'd0, 32'hFFFF_FFFF));
    queue_request(make_req(MODE_URANGE, 32'hFFFF_FFFF, 32'd0));
    queue_request(make_req(MODE_URANGE, 32'd77, 32'd77));
    queue_request(make_req(MODE_URANGE, 32'd10, 32'd3));
    queue_request(make_req(MODE_URANGE, 32'd0, 32'h8000_0000));
    queue_request(make_req(MODE_SRANGE, 32'h8000_0000, 32'h7FFF_FFFF));
    queue_request(make_req(MODE_SRANGE, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_request(make_req(MODE_SRANGE, 32'hFFFF_FFF6, 32'd5));
    queue_request(make_req(MODE_SRANGE, 32'd5, 32'hFFFF_FFF6));
    queue_request(make_req(MODE_SRANGE, 32'h8000_0000, 32'h8000_0000));
    queue_request(make_req(MODE_SRANGE, 32'hC000_0000, 32'h4000_0001));
    wait_drained();
    for (int phase = 0; phase < 4; phase++) begin
      write_seed(seeds[phase]);
      for (int i = 0; i < NUM_RANDOM / 4; i++) queue_request(random_req());
      wait_drained();
    end
    $display("Covered %0d requests in all eight modes across %0d seed settings;",
             sent_count, seed_writes + 1);
    $display("%0d results checked, %0d mismatches.", checked_count, error_count);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
